@@ rtl/core/brb_pkg.sv @@
// Shared widths and codes for the block reorder buffer.
// Used by block_reorder_buffer and its port checker; depends on nothing.
`default_nettype none

package brb_pkg;

  localparam int OffW   = 48;
  localparam int LenW   = 21;
  localparam int TagW   = 16;
  localparam int LimitW = 5;
  localparam int StatW  = 2;
  localparam int AddrW  = 4;
  localparam int DataW  = 64;

  localparam int SlotsDefault = 16;
  localparam logic [LimitW-1:0] LimitReset = 5'd16;

  localparam logic KIND_FLUSH  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [StatW-1:0] ST_OK       = 2'd0;
  localparam logic [StatW-1:0] ST_OVERFLOW = 2'd1;
  localparam logic [StatW-1:0] ST_UPSTREAM = 2'd2;

  localparam logic REG_START = 1'b0;
  localparam logic REG_LIMIT = 1'b1;

endpackage

`default_nettype wire

@@ rtl/core/block_reorder_buffer.sv @@
// Block reorder buffer: parks out-of-order blocks in slots and flushes them in order.
// Depends on brb_pkg for widths and result codes.
//
//   channel   direction  handshake                   payload
//   in        request    in_valid_i / in_stall_o     block_offset_i .. end_of_data_i
//   out       result     out_valid_o / out_stall_i   kind_o .. last_o
//   cfg       APB write  psel/penable/pwrite/pready  start_offset at 0, slot_limit at 8
//
// A request that stores nothing goes straight to its status result; otherwise the scan makes passes
// over the first cnt = min(slot_limit, SLOTS) slots, each used slot takes a memory read before its
// compare, and each pass ends with a step that decides on another pass.
// Reset leaves all slots free, the expected offset at zero and slot_limit at 16.
// Requests are taken one at a time; a stalled result holds the scan at the matching slot.
// The next request is taken while the previous status result still waits in the output.
`default_nettype none

module block_reorder_buffer #(
  parameter int SLOTS = brb_pkg::SlotsDefault
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            in_valid_i,
  output logic                           in_stall_o,
  input  wire  [brb_pkg::OffW-1:0]       block_offset_i,
  input  wire  [brb_pkg::LenW-1:0]       block_length_i,
  input  wire  [brb_pkg::TagW-1:0]       payload_tag_i,
  input  wire                            upstream_error_i,
  input  wire                            end_of_data_i,
  output logic                           out_valid_o,
  input  wire                            out_stall_i,
  output logic                           kind_o,
  output logic [brb_pkg::TagW-1:0]       out_tag_o,
  output logic [brb_pkg::OffW-1:0]       out_offset_o,
  output logic [brb_pkg::LenW-1:0]       out_length_o,
  output logic [brb_pkg::StatW-1:0]      status_o,
  output logic                           transfer_done_o,
  output logic                           last_o,
  input  wire                            psel,
  input  wire                            penable,
  input  wire                            pwrite,
  input  wire  [brb_pkg::AddrW-1:0]      paddr,
  input  wire  [brb_pkg::DataW-1:0]      pwdata,
  output logic [brb_pkg::DataW-1:0]      prdata,
  output logic                           pready
);

  localparam int IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CntW = ($clog2(SLOTS + 1) > brb_pkg::LimitW) ? $clog2(SLOTS + 1)
                                                              : brb_pkg::LimitW;
  localparam int EntW = brb_pkg::OffW + brb_pkg::LenW + brb_pkg::TagW;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_CMP  = 4'b0100,
    S_STAT = 4'b1000
  } state_e;

  state_e                      state_q, state_d;
  logic [CntW-1:0]             idx_q, idx_d;
  logic                        again_q, again_d;
  logic [SLOTS-1:0]            used_q, used_d;
  logic [brb_pkg::OffW-1:0]    exp_q, exp_d;
  logic                        done_q, done_d;
  logic [brb_pkg::StatW-1:0]   stat_q, stat_d;
  logic [brb_pkg::OffW-1:0]    start_q, start_d;
  logic [brb_pkg::LimitW-1:0]  limit_q, limit_d;
  logic                        out_valid_q, out_valid_d;

  logic [EntW-1:0]             mem [SLOTS];
  logic [EntW-1:0]             rd_q;
  logic [brb_pkg::OffW-1:0]    rd_off;
  logic [brb_pkg::LenW-1:0]    rd_len;
  logic [brb_pkg::TagW-1:0]    rd_tag;

  logic [CntW-1:0]             lim_ext;
  logic [CntW-1:0]             cnt;
  logic                        free_found;
  logic [IdxW-1:0]             free_idx;
  logic                        in_acc;
  logic                        out_free;
  logic                        cfg_we;
  logic                        mem_we;
  logic                        rd_en;
  logic                        load_flush;
  logic                        load_stat;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign cfg_we   = psel && penable && pwrite && pready;
  assign pready   = 1'b1;
  assign lim_ext  = CntW'(limit_q);
  assign cnt      = (lim_ext > CntW'(SLOTS)) ? CntW'(SLOTS) : lim_ext;
  assign {rd_off, rd_len, rd_tag} = rd_q;

  always_comb begin
    prdata = '0;
    if (paddr[3] == brb_pkg::REG_LIMIT) begin
      prdata = brb_pkg::DataW'(limit_q);
    end else begin
      prdata = brb_pkg::DataW'(start_q);
    end
  end

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!used_q[i] && (CntW'(i) < cnt)) begin
        free_found = 1'b1;
        free_idx   = IdxW'(i);
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    again_d     = again_q;
    used_d      = used_q;
    exp_d       = exp_q;
    done_d      = done_q;
    stat_d      = stat_q;
    start_d     = start_q;
    limit_d     = limit_q;
    out_valid_d = out_valid_q && out_stall_i;
    mem_we      = 1'b0;
    rd_en       = 1'b0;
    load_flush  = 1'b0;
    load_stat   = 1'b0;

    if (cfg_we) begin
      if (paddr[3] == brb_pkg::REG_LIMIT) begin
        limit_d = pwdata[brb_pkg::LimitW-1:0];
      end else begin
        start_d = pwdata[brb_pkg::OffW-1:0];
        exp_d   = pwdata[brb_pkg::OffW-1:0];
      end
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          stat_d  = upstream_error_i ? brb_pkg::ST_UPSTREAM : brb_pkg::ST_OK;
          done_d  = done_q || upstream_error_i || end_of_data_i;
          state_d = S_STAT;
          if (block_length_i != '0) begin
            if (free_found) begin
              mem_we           = 1'b1;
              used_d[free_idx] = 1'b1;
              stat_d           = brb_pkg::ST_OK;
              idx_d            = '0;
              again_d          = 1'b0;
              state_d          = S_SCAN;
            end else begin
              stat_d = brb_pkg::ST_OVERFLOW;
              done_d = 1'b1;
            end
          end
        end
      end
      S_SCAN: begin
        if (idx_q == cnt) begin
          if (again_q) begin
            idx_d   = '0;
            again_d = 1'b0;
          end else begin
            state_d = S_STAT;
          end
        end else if (used_q[idx_q[IdxW-1:0]]) begin
          rd_en   = 1'b1;
          state_d = S_CMP;
        end else begin
          idx_d = idx_q + CntW'(1);
        end
      end
      S_CMP: begin
        if (rd_off == exp_q) begin
          if (out_free) begin
            load_flush                 = 1'b1;
            out_valid_d                = 1'b1;
            used_d[idx_q[IdxW-1:0]]    = 1'b0;
            exp_d                      = exp_q + brb_pkg::OffW'(rd_len);
            again_d                    = 1'b1;
            idx_d                      = idx_q + CntW'(1);
            state_d                    = S_SCAN;
          end
        end else begin
          idx_d   = idx_q + CntW'(1);
          state_d = S_SCAN;
        end
      end
      S_STAT: begin
        if (out_free) begin
          load_stat   = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      again_q     <= 1'b0;
      used_q      <= '0;
      exp_q       <= '0;
      done_q      <= 1'b0;
      stat_q      <= brb_pkg::ST_OK;
      start_q     <= '0;
      limit_q     <= brb_pkg::LimitReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      again_q     <= again_d;
      used_q      <= used_d;
      exp_q       <= exp_d;
      done_q      <= done_d;
      stat_q      <= stat_d;
      start_q     <= start_d;
      limit_q     <= limit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[free_idx] <= {block_offset_i, block_length_i, payload_tag_i};
    end
    if (rd_en) begin
      rd_q <= mem[idx_q[IdxW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_flush) begin
      kind_o          <= brb_pkg::KIND_FLUSH;
      out_tag_o       <= rd_tag;
      out_offset_o    <= rd_off;
      out_length_o    <= rd_len;
      status_o        <= brb_pkg::ST_OK;
      transfer_done_o <= done_q;
      last_o          <= 1'b0;
    end else if (load_stat) begin
      kind_o          <= brb_pkg::KIND_STATUS;
      out_tag_o       <= '0;
      out_offset_o    <= '0;
      out_length_o    <= '0;
      status_o        <= stat_q;
      transfer_done_o <= done_q;
      last_o          <= 1'b1;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

@@ rtl/core/brb_checker.sv @@
// Port checker for block_reorder_buffer, attached to it by the bind at the end.
// Depends on brb_pkg for widths and result codes.
`default_nettype none

module brb_checker (
  input wire                        clk_i,
  input wire                        rst_ni,
  input wire                        in_valid_i,
  input wire                        in_stall_o,
  input wire                        out_valid_o,
  input wire                        out_stall_i,
  input wire                        kind_o,
  input wire [brb_pkg::TagW-1:0]    out_tag_o,
  input wire [brb_pkg::OffW-1:0]    out_offset_o,
  input wire [brb_pkg::LenW-1:0]    out_length_o,
  input wire [brb_pkg::StatW-1:0]   status_o,
  input wire                        transfer_done_o,
  input wire                        last_o
);

  a_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request accepted while the previous one is in work");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(kind_o) && $stable(out_tag_o)
      && $stable(out_offset_o) && $stable(out_length_o) && $stable(status_o)
      && $stable(transfer_done_o) && $stable(last_o))
    else $error("stalled result changed");

  a_status_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == brb_pkg::KIND_STATUS) |-> last_o && (out_tag_o == '0)
      && (out_offset_o == '0) && (out_length_o == '0))
    else $error("status result malformed");

  a_flush_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == brb_pkg::KIND_FLUSH) |-> !last_o
      && (status_o == brb_pkg::ST_OK) && (out_length_o != '0))
    else $error("flush result malformed");

  a_fail_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != brb_pkg::ST_OK) |-> transfer_done_o)
    else $error("failure status without done");

endmodule

bind block_reorder_buffer brb_checker u_brb_checker (.*);

`default_nettype wire
